// ===== hdl/atilt_pkg.sv =====
// ----------------------------------------------------------------------------
// atilt_pkg - shared types and constants for the tilt angle block
// Word widths, sequencer states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package atilt_pkg;

   localparam int AXIS_W    = 16;
   localparam int ALPHA_W   = 16;
   localparam int BETA_W    = 17;
   localparam int GUARD_W   = 8;
   localparam int VEC_W     = 27;             // CORDIC x/y datapath
   localparam int ANG_W     = 26;             // Q16 degree accumulator
   localparam int RND_W     = ANG_W - 8;      // Q8 angle before saturation
   localparam int PROD_W    = 44;             // gain product accumulator
   localparam int DIGIT_W   = 4;              // gain multiplier digit
   localparam int GAIN_W    = 16;
   localparam int NDIGITS   = GAIN_W / DIGIT_W;
   localparam int TABLE_LEN = 24;
   localparam int STEPS_DEF = 16;

   localparam logic [GAIN_W-1:0] GAIN_Q16  = 16'd39797;
   localparam logic [ANG_W-1:0]  ANG_P90   = 26'sd5898240;
   localparam logic [ANG_W-1:0]  ANG_M90   = -26'sd5898240;
   localparam logic signed [RND_W-1:0] ALPHA_LIM = 18'sd23040;
   localparam logic signed [RND_W-1:0] BETA_LIM  = 18'sd46080;

   localparam logic [1:0] MODE_XY     = 2'd0;
   localparam logic [1:0] MODE_X_ONLY = 2'd1;
   localparam logic [1:0] MODE_Y_ONLY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BETA,
      ST_YZ,
      ST_MUL,
      ST_ALPHA,
      ST_FINISH
   } state_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [ANG_W-1:0] atan_q16(input logic [4:0] idx);
      logic [ANG_W-1:0] v;
      unique case (idx)
         5'd0:  v = 26'd2949120;
         5'd1:  v = 26'd1740967;
         5'd2:  v = 26'd919879;
         5'd3:  v = 26'd466945;
         5'd4:  v = 26'd234379;
         5'd5:  v = 26'd117304;
         5'd6:  v = 26'd58666;
         5'd7:  v = 26'd29335;
         5'd8:  v = 26'd14668;
         5'd9:  v = 26'd7334;
         5'd10: v = 26'd3667;
         5'd11: v = 26'd1833;
         5'd12: v = 26'd917;
         5'd13: v = 26'd458;
         5'd14: v = 26'd229;
         5'd15: v = 26'd115;
         5'd16: v = 26'd57;
         5'd17: v = 26'd29;
         5'd18: v = 26'd14;
         5'd19: v = 26'd7;
         5'd20: v = 26'd4;
         5'd21: v = 26'd2;
         5'd22: v = 26'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Round Q16 to Q8 (floor of a+128) and clamp to +-lim
   function automatic logic signed [RND_W-1:0] round_sat(
      input logic signed [ANG_W-1:0] a,
      input logic signed [RND_W-1:0] lim);
      logic signed [ANG_W-1:0] s;
      logic signed [RND_W-1:0] r;
      s = a + ANG_W'(128);
      r = s[ANG_W-1:8];
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

endpackage

// ===== hdl/accel_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles - accelerometer tilt angles by CORDIC
// Iterative vectoring CORDIC with a digit-serial gain multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per sample (accel_x/y/z signed Q8, double_click).
//   A set double_click advances the display mode (both, x only, y only).
//   rsp_ channel: tilt_alpha = atan2(x, sqrt(y^2+z^2)), tilt_beta =
//   atan2(y, x), signed Q8 degrees, plus show_alpha / show_beta flags.
//   One sample is in flight at a time. It takes 3*CORDIC_STEPS shared
//   CORDIC iterations (one per cycle: beta run, y/z magnitude run, alpha
//   run), a digit-serial gain multiply with 4-bit digits and a load of the
//   output register. req_ready rises again together with rsp_valid, when
//   the result is loaded into the output register.
//   The output register holds a result while rsp_ready is low; the next
//   sample may be accepted and computed meanwhile, and finishes into the
//   output register once the held word is taken.
//   Synchronous reset clears the sequencer, the output valid and sets the
//   display mode to both angles shown.
// ----------------------------------------------------------------------------
module accel_tilt_angles #(
   parameter int CORDIC_STEPS = atilt_pkg::STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [atilt_pkg::AXIS_W-1:0]  req_accel_x,
   input  logic signed [atilt_pkg::AXIS_W-1:0]  req_accel_y,
   input  logic signed [atilt_pkg::AXIS_W-1:0]  req_accel_z,
   input  logic                                 req_double_click,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [atilt_pkg::ALPHA_W-1:0] rsp_tilt_alpha,
   output logic signed [atilt_pkg::BETA_W-1:0]  rsp_tilt_beta,
   output logic                                 rsp_show_alpha,
   output logic                                 rsp_show_beta
);
   import atilt_pkg::*;

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   state_type state_ff, state_in;

   logic signed [AXIS_W-1:0]  ax_ff, ay_ff, az_ff;
   logic [1:0]                mode_ff, mode_in;
   logic signed [VEC_W-1:0]   cx_ff, cy_ff, cx_in, cy_in;
   logic signed [ANG_W-1:0]   ang_ff, ang_in;
   logic                      zero_ff, zero_in;
   logic [STEP_W-1:0]         step_ff;
   logic signed [VEC_W-1:0]   mag_ff;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic [1:0]                dig_ff;
   logic signed [BETA_W-1:0]  beta_ff;
   logic signed [ALPHA_W-1:0] alpha_ff;
   logic                      rsp_valid_ff;
   logic signed [ALPHA_W-1:0] rsp_alpha_ff;
   logic signed [BETA_W-1:0]  rsp_beta_ff;
   logic                      rsp_sa_ff, rsp_sb_ff;

   logic                      accept, last_step, slot_free, load_run;
   logic signed [VEC_W-1:0]   ld_x, ld_y, xs, ys, r_mag;
   logic signed [ANG_W-1:0]   ld_ang, ang_fin;
   logic                      ld_zero;
   logic [DIGIT_W-1:0]        digit;
   logic signed [DIGIT_W+VEC_W:0] part;
   logic signed [PROD_W-1:0]  acc_rnd;
   logic signed [RND_W-1:0]   beta_r, alpha_r;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign last_step = (step_ff == LAST_STEP);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_BETA;
         ST_BETA:   if (last_step) state_in = ST_YZ;
         ST_YZ:     if (last_step) state_in = ST_MUL;
         ST_MUL:    if (dig_ff == 2'(NDIGITS - 1)) state_in = ST_ALPHA;
         ST_ALPHA:  if (last_step) state_in = ST_FINISH;
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- gain multiply, one digit a cycle ----------------
   always_comb begin
      logic [GAIN_W-1:0] gsh;
      logic signed [PROD_W-1:0] pext;
      gsh    = GAIN_Q16 >> {dig_ff, 2'b00};
      digit  = gsh[DIGIT_W-1:0];
      part   = mag_ff * $signed({1'b0, digit});
      pext   = PROD_W'(part);
      acc_in = acc_ff + (pext <<< {dig_ff, 2'b00});
      acc_rnd = acc_in + PROD_W'(32768);
      r_mag  = acc_rnd[VEC_W+15:16];
   end

   // ---------------- run operand select and pre-rotation ----------------
   always_comb begin
      logic signed [VEC_W-1:0] xv, yv;
      load_run = 1'b0;
      xv = '0;
      yv = '0;
      unique case (state_ff)
         ST_IDLE: begin
            load_run = accept;
            xv = VEC_W'($signed({req_accel_x, {GUARD_W{1'b0}}}));
            yv = VEC_W'($signed({req_accel_y, {GUARD_W{1'b0}}}));
         end
         ST_BETA: begin
            load_run = last_step;
            xv = VEC_W'($signed({ay_ff, {GUARD_W{1'b0}}}));
            yv = VEC_W'($signed({az_ff, {GUARD_W{1'b0}}}));
         end
         ST_MUL: begin
            load_run = (dig_ff == 2'(NDIGITS - 1));
            xv = r_mag;
            yv = VEC_W'($signed({ax_ff, {GUARD_W{1'b0}}}));
         end
         default: begin
            load_run = 1'b0;
         end
      endcase
      ld_zero = (xv == '0) && (yv == '0);
      if (xv < 0) begin
         if (yv >= 0) begin
            ld_x = yv;  ld_y = -xv; ld_ang = ANG_P90;
         end else begin
            ld_x = -yv; ld_y = xv;  ld_ang = ANG_M90;
         end
      end else begin
         ld_x = xv; ld_y = yv; ld_ang = '0;
      end
   end

   // ---------------- CORDIC iteration ----------------
   always_comb begin
      logic [ANG_W-1:0] at;
      xs = cx_ff >>> step_ff;
      ys = cy_ff >>> step_ff;
      at = atan_q16(5'(step_ff));
      if (cy_ff >= 0) begin
         cx_in  = cx_ff + ys;
         cy_in  = cy_ff - xs;
         ang_in = ang_ff + $signed(at);
      end else begin
         cx_in  = cx_ff - ys;
         cy_in  = cy_ff + xs;
         ang_in = ang_ff - $signed(at);
      end
      ang_fin = zero_ff ? '0 : ang_in;
      beta_r  = round_sat(ang_fin, BETA_LIM);
      alpha_r = round_sat(ang_fin, ALPHA_LIM);
      zero_in = zero_ff;
   end

   always_comb begin
      mode_in = mode_ff;
      if (accept && req_double_click) begin
         mode_in = (mode_ff >= MODE_Y_ONLY) ? MODE_XY : mode_ff + 2'd1;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_XY;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         dig_ff       <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         if (load_run) begin
            step_ff <= '0;
         end else if (state_ff == ST_BETA || state_ff == ST_YZ ||
                      state_ff == ST_ALPHA) begin
            step_ff <= step_ff + STEP_W'(1);
         end
         if (state_ff == ST_MUL) begin
            dig_ff <= dig_ff + 2'd1;
         end else begin
            dig_ff <= '0;
         end
         if (state_ff == ST_FINISH && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
      end
      if (load_run) begin
         cx_ff   <= ld_x;
         cy_ff   <= ld_y;
         ang_ff  <= ld_ang;
         zero_ff <= ld_zero;
      end else begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         ang_ff  <= ang_in;
         zero_ff <= zero_in;
      end
      if (state_ff == ST_BETA && last_step) begin
         beta_ff <= beta_r[BETA_W-1:0];
      end
      if (state_ff == ST_YZ && last_step) begin
         mag_ff <= cx_in;
      end
      if (state_ff == ST_MUL) begin
         acc_ff <= acc_in;
      end else begin
         acc_ff <= '0;
      end
      if (state_ff == ST_ALPHA && last_step) begin
         alpha_ff <= alpha_r[ALPHA_W-1:0];
      end
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_alpha_ff <= alpha_ff;
         rsp_beta_ff  <= beta_ff;
         rsp_sa_ff    <= (mode_ff == MODE_XY) || (mode_ff == MODE_X_ONLY);
         rsp_sb_ff    <= (mode_ff == MODE_XY) || (mode_ff == MODE_Y_ONLY);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tilt_alpha = rsp_alpha_ff;
   assign rsp_tilt_beta  = rsp_beta_ff;
   assign rsp_show_alpha = rsp_sa_ff;
   assign rsp_show_beta  = rsp_sb_ff;

endmodule
